>>> rtl/bpc_pkg.sv
// bpc_pkg: shared types and constants of the button press classifier
// no dependencies; used by bpc_cfg_regs, bpc_core and button_press_classifier
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned BtnW    = 8;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ACTIVE_HIGH     = 3'd0,
        REG_BUTTON_NUMBER   = 3'd1,
        REG_DEBOUNCE_TIME   = 3'd2,
        REG_SHORT_LIMIT     = 3'd3,
        REG_LONG_TIME       = 3'd4,
        REG_REPEAT_START    = 3'd5,
        REG_REPEAT_DEC      = 3'd6,
        REG_REPEAT_MIN      = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_DEBOUNCE  = 2'd1,
        MODE_HOLD      = 2'd2,
        MODE_HOLD_LONG = 2'd3
    } t_mode;

    typedef struct packed {
        logic            active_high;
        logic [BtnW-1:0] button_number;
        logic [CfgW-1:0] debounce_time;
        logic [CfgW-1:0] short_press_limit;
        logic [CfgW-1:0] long_press_time;
        logic [CfgW-1:0] repeat_start_interval;
        logic [CfgW-1:0] repeat_decrement;
        logic [CfgW-1:0] repeat_min_interval;
    } t_cfg;

    typedef struct packed {
        logic repeat_hit;
        logic long_press;
        logic short_press;
        logic released;
        logic pressed;
    } t_events;

endpackage

>>> rtl/button_press_classifier.sv
// button_press_classifier: top level with input register, classifier core and result register
// depends on bpc_pkg, bpc_cfg_regs and bpc_core
`timescale 1ns / 1ps

// One request is one poll of the button: raw pin level and a wrapping millisecond
// timestamp; each request yields exactly one result carrying the event flags and the
// configured button number. A request is taken into an input register, classified
// against the press state and written to the result register, so the block takes
// one request per cycle while the output side is not stalled. Configuration must be
// written through i_cfg_wr_en, i_cfg_index and i_cfg_wdata only while no request is
// in flight; the block itself does not enforce this.

module button_press_classifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bpc_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [bpc_pkg::CfgW-1:0]           i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pin_level [0], now_ms [32:1], zero [39:33]
    input  logic [bpc_pkg::InDataW-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pressed [0], released [1], short_press [2], long_press [3], repeat [4],
    // event_button [12:5], zero [15:13]
    output logic [bpc_pkg::OutDataW-1:0]       m_axis_tdata
);

    bpc_pkg::t_cfg    cfg;
    bpc_pkg::t_events events;

    logic                          r_in_valid;
    logic                          r_in_level;
    logic [bpc_pkg::TimeW-1:0]     r_in_now;
    logic                          r_out_valid;
    bpc_pkg::t_events              r_out_events;
    logic [bpc_pkg::BtnW-1:0]      r_out_button;

    logic out_free;
    logic adv;
    logic in_take;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_pin_level (r_in_level),
        .i_now_ms    (r_in_now),
        .i_cfg       (cfg),
        .o_events    (events)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_level <= s_axis_tdata[0];
            r_in_now   <= s_axis_tdata[bpc_pkg::TimeW:1];
        end
        if (adv) begin
            r_out_events <= events;
            r_out_button <= cfg.button_number;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_button, r_out_events.repeat_hit,
                            r_out_events.long_press, r_out_events.short_press,
                            r_out_events.released, r_out_events.pressed};

endmodule

>>> rtl/bpc_cfg_regs.sv
// bpc_cfg_regs: configuration register file written through the plain write port
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bpc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bpc_pkg::CfgW-1:0]     i_cfg_wdata,
    output bpc_pkg::t_cfg                o_cfg
);

    bpc_pkg::t_cfg r_cfg;
    bpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (bpc_pkg::t_reg_idx'(i_cfg_index))
                bpc_pkg::REG_ACTIVE_HIGH:   n_cfg.active_high = i_cfg_wdata[0];
                bpc_pkg::REG_BUTTON_NUMBER: n_cfg.button_number = i_cfg_wdata[bpc_pkg::BtnW-1:0];
                bpc_pkg::REG_DEBOUNCE_TIME: n_cfg.debounce_time = i_cfg_wdata;
                bpc_pkg::REG_SHORT_LIMIT:   n_cfg.short_press_limit = i_cfg_wdata;
                bpc_pkg::REG_LONG_TIME:     n_cfg.long_press_time = i_cfg_wdata;
                bpc_pkg::REG_REPEAT_START:  n_cfg.repeat_start_interval = i_cfg_wdata;
                bpc_pkg::REG_REPEAT_DEC:    n_cfg.repeat_decrement = i_cfg_wdata;
                bpc_pkg::REG_REPEAT_MIN:    n_cfg.repeat_min_interval = i_cfg_wdata;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high           <= 1'b0;
            r_cfg.button_number         <= '0;
            r_cfg.debounce_time         <= bpc_pkg::CfgW'(20);
            r_cfg.short_press_limit     <= bpc_pkg::CfgW'(1000);
            r_cfg.long_press_time       <= bpc_pkg::CfgW'(3000);
            r_cfg.repeat_start_interval <= bpc_pkg::CfgW'(700);
            r_cfg.repeat_decrement      <= bpc_pkg::CfgW'(50);
            r_cfg.repeat_min_interval   <= bpc_pkg::CfgW'(100);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/bpc_core.sv
// bpc_core: press state machine with timestamps and auto-repeat interval
// depends on bpc_pkg; state advances once per request taken from the input register
`timescale 1ns / 1ps

module bpc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_pin_level,
    input  logic [bpc_pkg::TimeW-1:0]    i_now_ms,
    input  bpc_pkg::t_cfg                i_cfg,
    output bpc_pkg::t_events             o_events
);

    bpc_pkg::t_mode r_mode, n_mode;
    logic           r_last_level, n_last_level;
    logic [bpc_pkg::TimeW-1:0] r_debounce_start, n_debounce_start;
    logic [bpc_pkg::TimeW-1:0] r_press_start, n_press_start;
    logic [bpc_pkg::TimeW-1:0] r_repeat_start, n_repeat_start;
    logic [bpc_pkg::CfgW-1:0]  r_repeat_interval, n_repeat_interval;

    logic level;
    logic rising_press;
    logic release_edge;
    logic [bpc_pkg::TimeW-1:0] since_debounce;
    logic [bpc_pkg::TimeW-1:0] since_press;
    logic [bpc_pkg::TimeW-1:0] since_repeat;
    logic debounce_done;
    logic is_short;
    logic long_due;
    logic repeat_due;
    logic [bpc_pkg::CfgW-1:0] interval_dec;
    logic [bpc_pkg::CfgW-1:0] interval_next;
    bpc_pkg::t_events ev;

    assign level          = i_pin_level ^ i_cfg.active_high;
    assign rising_press   = !level && r_last_level;
    assign release_edge   = level && !r_last_level;
    assign since_debounce = i_now_ms - r_debounce_start;
    assign since_press    = i_now_ms - r_press_start;
    assign since_repeat   = i_now_ms - r_repeat_start;
    assign debounce_done  = since_debounce >= bpc_pkg::TimeW'(i_cfg.debounce_time);
    assign is_short       = since_press <= bpc_pkg::TimeW'(i_cfg.short_press_limit);
    assign long_due       = since_press >= bpc_pkg::TimeW'(i_cfg.long_press_time);
    assign repeat_due     = since_repeat >= bpc_pkg::TimeW'(r_repeat_interval);

    // saturating decrement, clamped up to the minimum
    assign interval_dec  = (r_repeat_interval > i_cfg.repeat_decrement)
                         ? r_repeat_interval - i_cfg.repeat_decrement : '0;
    assign interval_next = (interval_dec <= i_cfg.repeat_min_interval)
                         ? i_cfg.repeat_min_interval : interval_dec;

    always_comb begin
        n_mode            = r_mode;
        n_last_level      = r_last_level;
        n_debounce_start  = r_debounce_start;
        n_press_start     = r_press_start;
        n_repeat_start    = r_repeat_start;
        n_repeat_interval = r_repeat_interval;
        ev                = '0;
        case (r_mode)
            bpc_pkg::MODE_IDLE: begin
                if (rising_press) begin
                    n_debounce_start = i_now_ms;
                    n_mode           = bpc_pkg::MODE_DEBOUNCE;
                end
            end
            bpc_pkg::MODE_DEBOUNCE: begin
                if (debounce_done) begin
                    if (rising_press) begin
                        ev.pressed        = 1'b1;
                        n_press_start     = i_now_ms;
                        n_last_level      = 1'b0;
                        n_repeat_start    = i_now_ms;
                        n_repeat_interval = i_cfg.repeat_start_interval;
                        n_mode            = bpc_pkg::MODE_HOLD;
                    end else if (release_edge) begin
                        ev.short_press = is_short;
                        ev.released    = 1'b1;
                        n_last_level   = 1'b1;
                        n_mode         = bpc_pkg::MODE_IDLE;
                    end else begin
                        n_last_level = 1'b1;
                        n_mode       = bpc_pkg::MODE_IDLE;
                    end
                end
            end
            bpc_pkg::MODE_HOLD: begin
                if (release_edge) begin
                    n_mode           = bpc_pkg::MODE_DEBOUNCE;
                    n_debounce_start = i_now_ms;
                end else if (long_due) begin
                    ev.long_press = 1'b1;
                    n_mode        = bpc_pkg::MODE_HOLD_LONG;
                end else if (repeat_due) begin
                    ev.repeat_hit     = 1'b1;
                    n_repeat_interval = interval_next;
                    n_repeat_start    = i_now_ms;
                end
            end
            default: begin
                if (release_edge) begin
                    n_mode           = bpc_pkg::MODE_DEBOUNCE;
                    n_debounce_start = i_now_ms;
                end else if (repeat_due) begin
                    ev.repeat_hit     = 1'b1;
                    n_repeat_interval = interval_next;
                    n_repeat_start    = i_now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= bpc_pkg::MODE_IDLE;
            r_last_level <= 1'b1;
        end else if (i_adv) begin
            r_mode       <= n_mode;
            r_last_level <= n_last_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_debounce_start  <= n_debounce_start;
            r_press_start     <= n_press_start;
            r_repeat_start    <= n_repeat_start;
            r_repeat_interval <= n_repeat_interval;
        end
    end

    assign o_events = ev;

    a_press_enters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && ev.pressed) |=> (r_mode == bpc_pkg::MODE_HOLD && !r_last_level))
        else $error("press event did not enter hold");

    a_release_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && ev.released) |=> (r_mode == bpc_pkg::MODE_IDLE && r_last_level))
        else $error("release event did not return to idle");

    a_long_enters_hold_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && ev.long_press) |=> (r_mode == bpc_pkg::MODE_HOLD_LONG))
        else $error("long press did not enter hold after long press");

    a_short_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev.short_press |-> (ev.released && r_mode == bpc_pkg::MODE_DEBOUNCE))
        else $error("short press without release");

    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_mode) && $stable(r_last_level)))
        else $error("state changed without a request");

endmodule
